// ===== rtl/core/lzwle_pkg.sv =====
`default_nettype none

package lzwle_pkg;

  // fixed field widths of the ports
  localparam int SYM_BITS   = 5;
  localparam int CODE_W     = 10;
  localparam int LIMIT_W    = 10;

  // defaults for the top level parameters
  localparam int CODE_BITS_DEF     = 10;
  localparam int ALPHABET_SIZE_DEF = 26;

  // code_limit after reset
  localparam logic [LIMIT_W-1:0] CODE_LIMIT_RESET = 10'd1023;

  // result queue geometry
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_BITS = 2;
  localparam int OUT_CNT_BITS = 3;

  typedef struct packed {
    logic [SYM_BITS-1:0] symbol;
    logic                end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
    logic              dict_full;
  } out_word_t;

  // which of the two result slots are pushed this cycle
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CHECK  = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lzwle_dict.sv =====
`default_nettype none

module lzwle_dict #(
  parameter int CODE_BITS = lzwle_pkg::CODE_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic [CODE_BITS+lzwle_pkg::SYM_BITS-1:0] child_rd_addr,
  input  wire logic [CODE_BITS-1:0]                     parent_rd_addr,
  input  wire logic                                     wr_en,
  input  wire logic [CODE_BITS+lzwle_pkg::SYM_BITS-1:0] wr_key,
  input  wire logic [CODE_BITS-1:0]                     wr_code,
  output logic      [CODE_BITS-1:0]                     child_out,
  output logic      [CODE_BITS+lzwle_pkg::SYM_BITS-1:0] parent_out
);

  localparam int KEY_BITS   = CODE_BITS + lzwle_pkg::SYM_BITS;
  localparam int KEY_DEPTH  = 1 << KEY_BITS;
  localparam int CODE_DEPTH = 1 << CODE_BITS;

  logic [CODE_BITS-1:0] child_mem [KEY_DEPTH];
  logic [KEY_BITS-1:0]  parent_mem [CODE_DEPTH];

  logic [CODE_BITS-1:0] child_q;
  logic [CODE_BITS-1:0] fwd_code;
  logic                 fwd;

  // child table: key -> candidate code
  always_ff @(posedge clk) begin
    if (wr_en) begin
      child_mem[wr_key] <= wr_code;
    end
    child_q <= child_mem[child_rd_addr];
  end

  // parent table: code -> key it was assigned under
  always_ff @(posedge clk) begin
    if (wr_en) begin
      parent_mem[wr_code] <= wr_key;
    end
    parent_out <= parent_mem[parent_rd_addr];
  end

  // write and read of the same key in one cycle: hand the new code over
  always_ff @(posedge clk) begin
    fwd      <= wr_en && (wr_key == child_rd_addr);
    fwd_code <= wr_code;
  end

  assign child_out = fwd ? fwd_code : child_q;

endmodule

`default_nettype wire

// ===== rtl/core/lzwle_fifo.sv =====
`default_nettype none

module lzwle_fifo (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire lzwle_pkg::push_t                      push,
  input  wire lzwle_pkg::out_word_t                  word_a,
  input  wire lzwle_pkg::out_word_t                  word_b,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output lzwle_pkg::out_word_t                       out_word,
  output logic [lzwle_pkg::OUT_CNT_BITS-1:0]         count
);

  lzwle_pkg::out_word_t mem [lzwle_pkg::OUT_DEPTH];

  logic [lzwle_pkg::OUT_PTR_BITS-1:0] wr_ptr;
  logic [lzwle_pkg::OUT_PTR_BITS-1:0] rd_ptr;
  logic [lzwle_pkg::OUT_CNT_BITS-1:0] n_push;
  logic                               pop;

  assign n_push    = lzwle_pkg::OUT_CNT_BITS'(push.first)
                   + lzwle_pkg::OUT_CNT_BITS'(push.second);
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_word  = mem[rd_ptr];

  // storage, up to two words a cycle in order
  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr] <= word_a;
    end
    if (push.second) begin
      mem[wr_ptr + lzwle_pkg::OUT_PTR_BITS'(1)] <= word_b;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + lzwle_pkg::OUT_PTR_BITS'(n_push);
      rd_ptr <= rd_ptr + lzwle_pkg::OUT_PTR_BITS'(pop);
      count  <= count + n_push - lzwle_pkg::OUT_CNT_BITS'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lzw_letter_encoder_top.sv =====
`default_nettype none

// channel   direction  handshake              word
// in        input      in_valid / in_ready    in_word (symbol, end_of_message)
// out       output     out_valid / out_ready  out_word (code, last, dict_full)
// cfg       input      cfg_write_en           cfg_write_data (code_limit)
//
// a letter goes through a child table read, then a parent table read, then the decision and update;
// these steps follow the read chain through the two dictionary memories
// a letter that finds the engine idle is first taken in ST_IDLE; a message's first letter needs no lookup
// the next letter is buffered while the current one is in the dictionary
// results go through a 4-word queue; the engine waits when fewer than 2 slots are free
// rst is synchronous; dictionary memories are not cleared, stale entries never hit

module lzw_letter_encoder_top #(
  parameter int CODE_BITS     = lzwle_pkg::CODE_BITS_DEF,
  parameter int ALPHABET_SIZE = lzwle_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire lzwle_pkg::in_word_t               in_word,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output lzwle_pkg::out_word_t                   out_word,
  input  wire logic                              cfg_write_en,
  input  wire logic [lzwle_pkg::LIMIT_W-1:0]     cfg_write_data
);

  localparam int SB         = lzwle_pkg::SYM_BITS;
  localparam int KEY_BITS   = CODE_BITS + SB;
  localparam int NFC_BITS   = CODE_BITS + 1;
  localparam int CODE_MAX   = (1 << CODE_BITS) - 1;
  localparam int CODE_SPACE = 1 << CODE_BITS;
  localparam logic [NFC_BITS-1:0] FIRST_FREE = NFC_BITS'(ALPHABET_SIZE + 1);

  // room for a growth step: next code within the limit and the code space
  function automatic logic can_add(input logic [NFC_BITS-1:0]           n,
                                   input logic [lzwle_pkg::LIMIT_W-1:0] lim);
    return (32'(n) <= 32'(lim)) && (32'(n) <= 32'(CODE_MAX));
  endfunction

  // registers
  lzwle_pkg::state_t                 state, state_next;
  logic [CODE_BITS-1:0]              prefix, prefix_next;
  logic [NFC_BITS-1:0]               nfc, nfc_next;
  logic [lzwle_pkg::LIMIT_W-1:0]     code_limit;
  logic                              ib_valid;
  lzwle_pkg::in_word_t               ib_word;
  logic [SB-1:0]                     cur_sym;
  logic                              cur_eom;
  logic [CODE_BITS-1:0]              child_r;

  // engine signals
  logic                              ib_take;
  logic                              cur_load;
  logic                              room;
  logic [SB-1:0]                     sym_c;
  logic [CODE_BITS-1:0]              ib_sym_code;
  logic [CODE_BITS-1:0]              cur_sym_code;
  logic [KEY_BITS-1:0]               key;
  logic                              hit;
  logic                              can_add_cur;
  logic [CODE_BITS-1:0]              prefix_mid;
  logic [NFC_BITS-1:0]               nfc_mid;
  lzwle_pkg::out_word_t              last_word;

  // dictionary port
  logic [KEY_BITS-1:0]               child_rd_addr;
  logic [CODE_BITS-1:0]              parent_rd_addr;
  logic                              wr_en;
  logic [KEY_BITS-1:0]               wr_key;
  logic [CODE_BITS-1:0]              wr_code;
  logic [CODE_BITS-1:0]              child_out;
  logic [KEY_BITS-1:0]               parent_out;

  // result queue port
  lzwle_pkg::push_t                  push;
  lzwle_pkg::out_word_t              word_a;
  lzwle_pkg::out_word_t              word_b;
  logic [lzwle_pkg::OUT_CNT_BITS-1:0] fifo_count;

  lzwle_dict #(
    .CODE_BITS (CODE_BITS)
  ) u_dict (
    .clk            (clk),
    .child_rd_addr  (child_rd_addr),
    .parent_rd_addr (parent_rd_addr),
    .wr_en          (wr_en),
    .wr_key         (wr_key),
    .wr_code        (wr_code),
    .child_out      (child_out),
    .parent_out     (parent_out)
  );

  lzwle_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .word_a    (word_a),
    .word_b    (word_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .count     (fifo_count)
  );

  // out-of-range letters fold onto the last letter
  always_comb begin
    if (32'(ib_word.symbol) >= 32'(ALPHABET_SIZE)) begin
      sym_c = SB'(ALPHABET_SIZE - 1);
    end else begin
      sym_c = ib_word.symbol;
    end
  end

  assign ib_sym_code  = CODE_BITS'(sym_c) + CODE_BITS'(1);
  assign cur_sym_code = CODE_BITS'(cur_sym) + CODE_BITS'(1);
  assign key          = {prefix, cur_sym};
  assign room         = (fifo_count <= lzwle_pkg::OUT_CNT_BITS'(lzwle_pkg::OUT_DEPTH - 2));
  assign can_add_cur  = can_add(nfc, code_limit);
  assign in_ready     = !ib_valid || ib_take;

  // a hit needs a code of this dictionary whose parent key matches
  assign hit = (child_r > CODE_BITS'(ALPHABET_SIZE))
            && (NFC_BITS'(child_r) < nfc)
            && (parent_out == key);

  // letter engine
  always_comb begin
    state_next     = state;
    prefix_next    = prefix;
    nfc_next       = nfc;
    ib_take        = 1'b0;
    cur_load       = 1'b0;
    child_rd_addr  = {prefix, sym_c};
    parent_rd_addr = child_r;
    wr_en          = 1'b0;
    wr_key         = key;
    wr_code        = CODE_BITS'(nfc);
    push           = '0;
    word_a         = '0;
    word_b         = '0;
    prefix_mid     = prefix;
    nfc_mid        = nfc;
    last_word      = '0;

    case (state)
      lzwle_pkg::ST_IDLE: begin
        if (ib_valid && room) begin
          ib_take = 1'b1;
          if (prefix == '0) begin
            // first letter of a message: no lookup
            prefix_next = ib_sym_code;
            if (ib_word.end_of_message) begin
              push.first       = 1'b1;
              word_a.code      = lzwle_pkg::CODE_W'(ib_sym_code);
              word_a.last      = 1'b1;
              word_a.dict_full = !can_add(nfc, code_limit);
              prefix_next      = '0;
              nfc_next         = FIRST_FREE;
            end
          end else begin
            cur_load   = 1'b1;
            state_next = lzwle_pkg::ST_CHECK;
          end
        end
      end

      lzwle_pkg::ST_CHECK: begin
        parent_rd_addr = child_out;
        state_next     = lzwle_pkg::ST_DECIDE;
      end

      lzwle_pkg::ST_DECIDE: begin
        if (room) begin
          // extend the prefix, or emit it and grow the dictionary
          if (hit) begin
            prefix_mid = child_r;
          end else begin
            prefix_mid = cur_sym_code;
            if (can_add_cur) begin
              wr_en   = 1'b1;
              nfc_mid = nfc + NFC_BITS'(1);
            end
            push.first       = 1'b1;
            word_a.code      = lzwle_pkg::CODE_W'(prefix);
            word_a.last      = 1'b0;
            word_a.dict_full = !can_add_cur;
          end

          if (cur_eom) begin
            // flush the final prefix and start a new dictionary
            last_word.code      = lzwle_pkg::CODE_W'(prefix_mid);
            last_word.last      = 1'b1;
            last_word.dict_full = !can_add(nfc_mid, code_limit);
            if (push.first) begin
              push.second = 1'b1;
              word_b      = last_word;
            end else begin
              push.first = 1'b1;
              word_a     = last_word;
            end
            prefix_next = '0;
            nfc_next    = FIRST_FREE;
            state_next  = lzwle_pkg::ST_IDLE;
          end else begin
            prefix_next = prefix_mid;
            nfc_next    = nfc_mid;
            if (ib_valid) begin
              // issue the next lookup with the updated prefix
              ib_take       = 1'b1;
              cur_load      = 1'b1;
              child_rd_addr = {prefix_mid, sym_c};
              state_next    = lzwle_pkg::ST_CHECK;
            end else begin
              state_next = lzwle_pkg::ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_next = lzwle_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lzwle_pkg::ST_IDLE;
      prefix     <= '0;
      nfc        <= FIRST_FREE;
      code_limit <= lzwle_pkg::CODE_LIMIT_RESET;
      ib_valid   <= 1'b0;
    end else begin
      state  <= state_next;
      prefix <= prefix_next;
      nfc    <= nfc_next;
      if (cfg_write_en) begin
        code_limit <= cfg_write_data;
      end
      if (in_valid && in_ready) begin
        ib_valid <= 1'b1;
      end else if (ib_take) begin
        ib_valid <= 1'b0;
      end
    end
  end

  // input word buffer and current letter
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib_word <= in_word;
    end
    if (cur_load) begin
      cur_sym <= sym_c;
      cur_eom <= ib_word.end_of_message;
    end
    if (state == lzwle_pkg::ST_CHECK) begin
      child_r <= child_out;
    end
  end

`ifndef NO_ASSERTIONS
  a_wr_only_decide: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == lzwle_pkg::ST_DECIDE) && room)
    else $error("dictionary write outside a decide step");

  a_check_to_decide: assert property (@(posedge clk) disable iff (rst)
    (state == lzwle_pkg::ST_CHECK) |=> (state == lzwle_pkg::ST_DECIDE))
    else $error("check step not followed by decide");

  a_nfc_range: assert property (@(posedge clk) disable iff (rst)
    (nfc >= FIRST_FREE) && (32'(nfc) <= 32'(CODE_SPACE)))
    else $error("next free code out of range");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fifo_count) <= 32'(lzwle_pkg::OUT_DEPTH))
    else $error("result queue overflow");

  a_eom_restart: assert property (@(posedge clk) disable iff (rst)
    (state == lzwle_pkg::ST_DECIDE) && room && cur_eom
      |=> (prefix == '0) && (nfc == FIRST_FREE))
    else $error("dictionary not restarted after end of message");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lzwle_pkg::*;

  localparam int LETTERS       = ALPHABET_SIZE_DEF;
  localparam int KEY_DEPTH     = 1 << (CODE_W + SYM_BITS);
  localparam int CODE_DEPTH    = 1 << CODE_W;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 110;

  logic                 clk;
  logic                 rst            = 1'b1;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  in_word_t             in_word        = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  out_word_t            out_word;
  logic                 cfg_write_en   = 1'b0;
  logic [LIMIT_W-1:0]   cfg_write_data = '0;

  // encoder state as seen by the predictor
  logic [CODE_W-1:0]          cur_prefix;
  int                         next_code;
  logic [LIMIT_W-1:0]         limit_reg;
  logic [CODE_W-1:0]          child_of [0:KEY_DEPTH-1];
  logic [CODE_W+SYM_BITS-1:0] key_of   [0:CODE_DEPTH-1];

  // codes still owed by the block, oldest first
  out_word_t code_q[$];

  int err_cnt     = 0;
  int cycle_cnt   = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_ticket = 0;

  // directed stimulus, expected words typed in where obvious
  typedef struct {
    logic [SYM_BITS-1:0] sym;
    logic                eom;
    bit                  typed;
    int                  n;
    out_word_t           e0;
    out_word_t           e1;
  } dir_row_t;

  dir_row_t dir_tbl[$];

  lzw_letter_encoder_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word       (out_word),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_word_t ow(input int c, input bit l, input bit f);
    return '{code: CODE_W'(c), last: l, dict_full: f};
  endfunction

  // one letter through the dictionary; returns the number of codes emitted
  function automatic int encode_letter(input logic [SYM_BITS-1:0] sym_in, input logic eom,
                                       output out_word_t r0, output out_word_t r1);
    logic [SYM_BITS-1:0]        sym;
    logic [CODE_W+SYM_BITS-1:0] key;
    logic [CODE_W-1:0]          child;
    out_word_t                  res [2];
    bit                         added;
    int                         n;
    n      = 0;
    res[0] = '0;
    res[1] = '0;
    // out-of-range letters fold onto the last letter
    sym = (sym_in >= LETTERS) ? SYM_BITS'(LETTERS - 1) : sym_in;
    if (cur_prefix == '0) begin
      cur_prefix = CODE_W'(sym) + CODE_W'(1);
    end else begin
      key   = {cur_prefix, sym};
      child = child_of[key];
      if (child > LETTERS && int'(child) < next_code && key_of[child] == key) begin
        cur_prefix = child;
      end else begin
        added = (next_code <= int'(limit_reg)) && (next_code < CODE_DEPTH);
        if (added) begin
          child_of[key]     = CODE_W'(next_code);
          key_of[next_code] = key;
          next_code++;
        end
        res[n] = ow(cur_prefix, 1'b0, !added);
        n++;
        cur_prefix = CODE_W'(sym) + CODE_W'(1);
      end
    end
    // end of message flushes the prefix and restarts the dictionary
    if (eom) begin
      res[n] = ow(cur_prefix, 1'b1, next_code > int'(limit_reg));
      n++;
      cur_prefix = '0;
      next_code  = LETTERS + 1;
    end
    r0 = res[0];
    r1 = res[1];
    return n;
  endfunction

  task automatic dir_row(input int sym, input bit eom, input bit typed = 1'b0,
                         input int n = 0, input out_word_t e0 = '0,
                         input out_word_t e1 = '0);
    dir_row_t row;
    row.sym   = SYM_BITS'(sym);
    row.eom   = eom;
    row.typed = typed;
    row.n     = n;
    row.e0    = e0;
    row.e1    = e1;
    dir_tbl.insert(dir_tbl.size(), row);
  endtask

  // offer one letter, wait for the handshake, then record the owed codes
  task automatic send_letter(input logic [SYM_BITS-1:0] sym, input logic eom,
                             input bit typed = 1'b0, input int n = 0,
                             input out_word_t e0 = '0, input out_word_t e1 = '0);
    out_word_t r0;
    out_word_t r1;
    int        k;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{symbol: sym, end_of_message: eom};
    do @(posedge clk); while (!in_ready);
    k = encode_letter(sym, eom, r0, r1);
    if (typed) begin
      k  = n;
      r0 = e0;
      r1 = e1;
    end
    if (k > 0) code_q.insert(code_q.size(), r0);
    if (k > 1) code_q.insert(code_q.size(), r1);
  endtask

  // let the block go quiet: all codes back, then room for a silent letter
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (code_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_code_limit(input logic [LIMIT_W-1:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    limit_reg = v;
  endtask

  // receiver: random stalls, one long hold-off on request, word checks
  int        hold_left = 0;
  int        hold_seen = 0;
  out_word_t want_word;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_seen != hold_ticket) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    if (!rst && out_valid && out_ready) begin
      if (code_q.size() == 0) begin
        $error("unexpected word: code %0d last %0d dict_full %0d",
               out_word.code, out_word.last, out_word.dict_full);
        err_cnt++;
      end else begin
        want_word = code_q.pop_front();
        if (out_word.code !== want_word.code) begin
          $error("code: expected %0d, got %0d", want_word.code, out_word.code);
          err_cnt++;
        end
        if (out_word.last !== want_word.last) begin
          $error("last: expected %0d, got %0d", want_word.last, out_word.last);
          err_cnt++;
        end
        if (out_word.dict_full !== want_word.dict_full) begin
          $error("dict_full: expected %0d, got %0d", want_word.dict_full,
                 out_word.dict_full);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    logic [LIMIT_W-1:0] phase_limit [10];
    logic [SYM_BITS-1:0] sym;
    int msg_left;
    int alpha_n;
    int alpha_base;
    int r;

    phase_limit = '{10'd27, 10'd60, 10'd0, 10'd1023, 10'd26,
                    10'd100, 10'd1, 10'd300, 10'd1023, 10'd45};
    msg_left   = 0;
    alpha_n    = 1;
    alpha_base = 0;

    foreach (child_of[i]) child_of[i] = '0;
    foreach (key_of[i]) key_of[i] = '0;
    cur_prefix = '0;
    next_code  = LETTERS + 1;
    limit_reg  = CODE_LIMIT_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: one-letter messages, letter extremes, a repeated letter
    dir_row(0, 1, 1, 1, ow(1, 1, 0));
    dir_row(31, 1, 1, 1, ow(26, 1, 0));
    dir_row(25, 1, 1, 1, ow(26, 1, 0));
    dir_row(0, 0, 1, 0);
    dir_row(0, 0, 1, 1, ow(1, 0, 0));
    dir_row(0, 0, 1, 0);
    dir_row(0, 1, 1, 2, ow(27, 0, 0), ow(1, 1, 0));
    // banana, then out-of-range letters inside a message
    dir_row(1, 0);
    dir_row(0, 0);
    dir_row(13, 0);
    dir_row(0, 0);
    dir_row(13, 0);
    dir_row(0, 1);
    dir_row(2, 0);
    dir_row(28, 0);
    dir_row(25, 0);
    dir_row(30, 0);
    dir_row(26, 0);
    dir_row(29, 1);
    foreach (dir_tbl[i])
      send_letter(dir_tbl[i].sym, dir_tbl[i].eom, dir_tbl[i].typed, dir_tbl[i].n,
                  dir_tbl[i].e0, dir_tbl[i].e1);

    // random phases; a message may run across a limit change
    foreach (phase_limit[p]) begin
      drain();
      write_code_limit(phase_limit[p]);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 79;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 79;
        end
        default: begin
          idle_pct  = 23;
          stall_pct = 23;
        end
      endcase
      // long receiver hold-off while letters keep coming
      if (p == 2) hold_ticket++;

      repeat (PHASE_ITEMS) begin
        if (msg_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 10)      msg_left = 1;
          else if (r < 80) msg_left = $urandom_range(2, 30);
          else if (r < 95) msg_left = $urandom_range(31, 120);
          else             msg_left = $urandom_range(150, 400);
          // narrow alphabets give long dictionary matches
          alpha_n    = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, LETTERS);
          alpha_base = $urandom_range(0, LETTERS - 1);
        end
        if ($urandom_range(0, 99) < 4)
          sym = SYM_BITS'($urandom_range(LETTERS, 31));
        else
          sym = SYM_BITS'((alpha_base + $urandom_range(0, alpha_n - 1)) % LETTERS);
        send_letter(sym, msg_left == 1);
        msg_left--;
      end
    end

    drain();
    if (err_cnt == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire
